@@ sv/capsule_support_point_unit_defines.svh @@
// Assertion helpers for the file that checks its own logic.
`ifndef CAPSULE_SUPPORT_POINT_UNIT_DEFINES_SVH
`define CAPSULE_SUPPORT_POINT_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define CSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/csp_pkg.sv @@
package csp_pkg;

  localparam int unsigned NumComp    = 3;
  localparam int unsigned MagW       = 32;
  localparam int unsigned SqW        = 64;
  localparam int unsigned RootW      = 32;
  localparam int unsigned QuotW      = 31;
  localparam int unsigned RadiusW    = 31;
  localparam int unsigned HalfW      = 30;
  localparam int unsigned ProdW      = 63;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLength = 2'd1;

  typedef logic [NumComp-1:0][MagW-1:0] mag_vec_t;

  typedef struct packed {
    mag_vec_t           mag;
    logic [NumComp-1:0] neg;
    logic               zero;
  } dir_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ sv/csp_front.sv @@
module csp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  dir_x_i,
  input  logic signed [31:0]  dir_y_i,
  input  logic signed [31:0]  dir_z_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output csp_pkg::dir_item_t  item_o
);

  logic                            en;
  logic                            a_v_q;
  csp_pkg::mag_vec_t               a_mag_q;
  logic [csp_pkg::NumComp-1:0]     a_neg_q;
  logic                            b_v_q;
  csp_pkg::dir_item_t              b_q;
  logic [csp_pkg::NumComp-1:0][31:0] dir;
  csp_pkg::mag_vec_t               mag_d;
  logic [csp_pkg::NumComp-1:0]     neg_d;
  logic [31:0]                     big;
  logic [4:0]                      k;
  csp_pkg::dir_item_t              b_d;

  assign en         = !(b_v_q && !item_ready_i);
  assign in_ready_o = en;

  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // Magnitudes; the most negative value maps to 2^31, which fits unsigned.
  always_comb begin
    for (int i = 0; i < csp_pkg::NumComp; i++) begin
      neg_d[i] = dir[i][31];
      mag_d[i] = dir[i][31] ? 32'(-dir[i]) : dir[i];
    end
  end

  // Common left shift that brings the largest magnitude to at least 2^30.
  always_comb begin
    big = a_mag_q[0];
    if (a_mag_q[1] > big) big = a_mag_q[1];
    if (a_mag_q[2] > big) big = a_mag_q[2];
    k = 5'd0;
    for (int p = 0; p < 31; p++) begin
      if (big[p]) k = 5'(30 - p);
    end
    if (big[31]) k = 5'd0;
    for (int i = 0; i < csp_pkg::NumComp; i++) begin
      b_d.mag[i] = a_mag_q[i] << k;
    end
    b_d.neg  = a_neg_q;
    b_d.zero = (big == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      a_mag_q <= mag_d;
      a_neg_q <= neg_d;
    end
    if (en && a_v_q) begin
      b_q <= b_d;
    end
  end

  assign item_valid_o = b_v_q;
  assign item_o       = b_q;

endmodule

@@ sv/csp_queue.sv @@
module csp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  csp_pkg::dir_item_t     data_i,
  input  logic                   pop_i,
  output csp_pkg::dir_item_t     data_o,
  output csp_pkg::queue_status_t status_o
);

  csp_pkg::dir_item_t             mem_q [csp_pkg::QueueDepth];
  logic [csp_pkg::QueuePtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [csp_pkg::QueuePtrW:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == (csp_pkg::QueuePtrW+1)'(csp_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

@@ sv/csp_back.sv @@
module csp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  csp_pkg::dir_item_t            item_i,
  output logic                          pop_o,
  input  logic [csp_pkg::RadiusW-1:0]   radius_i,
  input  logic [csp_pkg::HalfW-1:0]     half_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            support_x_o,
  output logic signed [31:0]            support_y_o,
  output logic signed [31:0]            support_z_o
);

  localparam int unsigned N  = csp_pkg::NumComp;
  localparam int unsigned L  = csp_pkg::SqrtSteps;
  localparam int unsigned QW = csp_pkg::QuotW;

  typedef logic [N-1:0][csp_pkg::SqW-1:0]   sq_vec_t;
  typedef logic [N-1:0][csp_pkg::RootW-1:0] rem_vec_t;
  typedef logic [N-1:0][QW-1:0]             quo_vec_t;

  logic adv;

  // Squares.
  logic              v0_q;
  sq_vec_t           sq0_q;
  csp_pkg::mag_vec_t sm0_q;
  logic [N-1:0]      neg0_q;
  logic              z0_q;
  // Sum of squares.
  logic              v1_q;
  logic [csp_pkg::SqW-1:0] sum1_q;
  csp_pkg::mag_vec_t sm1_q;
  logic [N-1:0]      neg1_q;
  logic              z1_q;
  // Root steps.
  logic              sv_q   [L];
  logic [csp_pkg::SqW-1:0] sx_q [L], sx_d [L], sxin [L];
  logic [csp_pkg::SqW-1:0] sr_q [L], sr_d [L], srin [L];
  csp_pkg::mag_vec_t ssm_q  [L];
  logic [N-1:0]      sneg_q [L];
  logic              sz_q   [L];
  // Radius products.
  logic              vm_q;
  logic [N-1:0][csp_pkg::ProdW-1:0] pm_q;
  logic [csp_pkg::RootW-1:0] rootm_q;
  logic [N-1:0]      negm_q;
  logic              zm_q;
  // Rounding and divider set-up.
  logic              vr_q;
  rem_vec_t          remr_q;
  quo_vec_t          lowr_q;
  logic [csp_pkg::RootW-1:0] rootr_q;
  logic [N-1:0]      negr_q;
  logic              zr_q;
  logic [csp_pkg::ProdW-1:0] dvd [N];
  // Divider steps.
  logic              dv_q    [QW];
  rem_vec_t          drem_q  [QW], drem_d [QW], dremin [QW];
  quo_vec_t          dlow_q  [QW], dlowin [QW];
  quo_vec_t          dquo_q  [QW], dquo_d [QW], dquoin [QW];
  logic [csp_pkg::RootW-1:0] droot_q [QW], drootin [QW];
  logic [N-1:0]      dneg_q  [QW];
  logic              dz_q    [QW];
  // Output.
  logic              out_v_q;
  logic signed [31:0] sx_out_q, sy_out_q, sz_out_q;
  logic signed [33:0] w [N];
  logic signed [31:0] sat [N];

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && item_valid_i;

  always_comb begin
    sxin[0] = sum1_q;
    srin[0] = '0;
    for (int j = 1; j < L; j++) begin
      sxin[j] = sx_q[j-1];
      srin[j] = sr_q[j-1];
    end
    for (int j = 0; j < L; j++) begin
      logic [csp_pkg::SqW-1:0] bitv;
      logic [csp_pkg::SqW-1:0] trial;
      bitv  = 64'd1 << (62 - 2 * j);
      trial = srin[j] + bitv;
      if (sxin[j] >= trial) begin
        sx_d[j] = sxin[j] - trial;
        sr_d[j] = (srin[j] >> 1) + bitv;
      end else begin
        sx_d[j] = sxin[j];
        sr_d[j] = srin[j] >> 1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      dvd[i] = pm_q[i] + csp_pkg::ProdW'(rootm_q >> 1);
    end
  end

  always_comb begin
    dremin[0]  = remr_q;
    dlowin[0]  = lowr_q;
    dquoin[0]  = '0;
    drootin[0] = rootr_q;
    for (int t = 1; t < QW; t++) begin
      dremin[t]  = drem_q[t-1];
      dlowin[t]  = dlow_q[t-1];
      dquoin[t]  = dquo_q[t-1];
      drootin[t] = droot_q[t-1];
    end
    for (int t = 0; t < QW; t++) begin
      for (int i = 0; i < N; i++) begin
        logic [csp_pkg::RootW:0] cand;
        logic                    ge;
        cand = {dremin[t][i], dlowin[t][i][QW-1-t]};
        ge   = cand >= {1'b0, drootin[t]};
        drem_d[t][i] = ge ? csp_pkg::RootW'(cand - {1'b0, drootin[t]})
                          : cand[csp_pkg::RootW-1:0];
        dquo_d[t][i] = {dquoin[t][i][QW-2:0], ge};
      end
    end
  end

  // Signed spherical part plus the end-cap offset on z, clamped to 32 bits.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic signed [33:0] q;
      q = $signed({3'b000, dquo_q[QW-1][i]});
      if (dz_q[QW-1]) q = '0;
      w[i] = dneg_q[QW-1][i] ? -q : q;
    end
    if (dneg_q[QW-1][2]) w[2] = w[2] - $signed({4'b0000, half_i});
    else                 w[2] = w[2] + $signed({4'b0000, half_i});
    for (int i = 0; i < N; i++) begin
      if (w[i] > 34'sh0_7FFF_FFFF)       sat[i] = 32'sh7FFF_FFFF;
      else if (w[i] < -34'sh0_8000_0000) sat[i] = 32'sh8000_0000;
      else                               sat[i] = w[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      vm_q    <= 1'b0;
      vr_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < L; j++) sv_q[j] <= 1'b0;
      for (int t = 0; t < QW; t++) dv_q[t] <= 1'b0;
    end else if (adv) begin
      v0_q    <= item_valid_i;
      v1_q    <= v0_q;
      sv_q[0] <= v1_q;
      for (int j = 1; j < L; j++) sv_q[j] <= sv_q[j-1];
      vm_q    <= sv_q[L-1];
      vr_q    <= vm_q;
      dv_q[0] <= vr_q;
      for (int t = 1; t < QW; t++) dv_q[t] <= dv_q[t-1];
      out_v_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        sq0_q[i] <= csp_pkg::SqW'(item_i.mag[i]) * csp_pkg::SqW'(item_i.mag[i]);
      end
      sm0_q  <= item_i.mag;
      neg0_q <= item_i.neg;
      z0_q   <= item_i.zero;

      sum1_q <= sq0_q[0] + sq0_q[1] + sq0_q[2];
      sm1_q  <= sm0_q;
      neg1_q <= neg0_q;
      z1_q   <= z0_q;

      ssm_q[0]  <= sm1_q;
      sneg_q[0] <= neg1_q;
      sz_q[0]   <= z1_q;
      for (int j = 1; j < L; j++) begin
        ssm_q[j]  <= ssm_q[j-1];
        sneg_q[j] <= sneg_q[j-1];
        sz_q[j]   <= sz_q[j-1];
      end
      for (int j = 0; j < L; j++) begin
        sx_q[j] <= sx_d[j];
        sr_q[j] <= sr_d[j];
      end

      for (int i = 0; i < N; i++) begin
        pm_q[i] <= csp_pkg::ProdW'(radius_i) * csp_pkg::ProdW'(ssm_q[L-1][i]);
      end
      rootm_q <= sr_q[L-1][csp_pkg::RootW-1:0];
      negm_q  <= sneg_q[L-1];
      zm_q    <= sz_q[L-1];

      for (int i = 0; i < N; i++) begin
        remr_q[i] <= dvd[i][csp_pkg::ProdW-1:QW];
        lowr_q[i] <= dvd[i][QW-1:0];
      end
      rootr_q <= rootm_q;
      negr_q  <= negm_q;
      zr_q    <= zm_q;

      dlow_q[0]  <= lowr_q;
      droot_q[0] <= rootr_q;
      dneg_q[0]  <= negr_q;
      dz_q[0]    <= zr_q;
      for (int t = 1; t < QW; t++) begin
        dlow_q[t]  <= dlow_q[t-1];
        droot_q[t] <= droot_q[t-1];
        dneg_q[t]  <= dneg_q[t-1];
        dz_q[t]    <= dz_q[t-1];
      end
      for (int t = 0; t < QW; t++) begin
        drem_q[t] <= drem_d[t];
        dquo_q[t] <= dquo_d[t];
      end

      sx_out_q <= sat[0];
      sy_out_q <= sat[1];
      sz_out_q <= sat[2];
    end
  end

  assign out_valid_o = out_v_q;
  assign support_x_o = sx_out_q;
  assign support_y_o = sy_out_q;
  assign support_z_o = sz_out_q;

endmodule

@@ sv/capsule_support_point_unit.sv @@
// Throughput: one beat per cycle while the output is not held; the 32-step root pipeline
// and 31-step divider pipeline each take a new direction every cycle they advance, and a
// four-entry queue decouples front and back.
// Reset (rst_ni low, asynchronous): pipelines and queue empty, radius 1.0, length 2.0.
`include "capsule_support_point_unit_defines.svh"

// The front end takes each direction beat, forms the component magnitudes and
// shifts all three left together so the largest lands at or above 2^30. Those
// items wait in a short queue. The back end squares and sums the scaled
// components, takes the floor integer root, then divides radius times each
// magnitude by the root with rounding to nearest. The sign is restored, half
// the cylinder length is added or subtracted on z by the sign of dir_z, and
// every component is clamped to the signed 32-bit range.
//
// The back end advances as a whole whenever its output register is free or
// being drained. A zero direction flows through the same path and is forced
// to the bare end-cap offset at the end.
module capsule_support_point_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [csp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [30:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           dir_x_i,
  input  logic signed [31:0]           dir_y_i,
  input  logic signed [31:0]           dir_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           support_x_o,
  output logic signed [31:0]           support_y_o,
  output logic signed [31:0]           support_z_o
);

  // Register reset values are 1.0 and 2.0 in the configured fixed-point format.
  localparam logic [csp_pkg::RadiusW-1:0] RadiusReset = 31'd1 << FRAC_BITS;
  localparam logic [csp_pkg::RadiusW-1:0] LengthReset = 31'd2 << FRAC_BITS;

  logic [csp_pkg::RadiusW-1:0] radius_q;
  logic [csp_pkg::RadiusW-1:0] length_q;

  logic                   fe_valid;
  csp_pkg::dir_item_t     fe_item;
  csp_pkg::dir_item_t     q_item;
  csp_pkg::queue_status_t q_status;
  logic                   q_push;
  logic                   q_pop;

  // Sign-extended x and zero-extended radius for the radius bound check.
  logic signed [32:0]     x_ext;
  logic signed [32:0]     rad_ext;

  // Writes to indexes past the two registers fall on no register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      length_q <= LengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        csp_pkg::CfgRadius: radius_q <= cfg_data_i;
        csp_pkg::CfgLength: length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .item_valid_o (fe_valid),
    .item_ready_i (!q_status.full),
    .item_o       (fe_item)
  );

  assign q_push = fe_valid && !q_status.full;

  csp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (fe_item),
    .pop_i    (q_pop),
    .data_o   (q_item),
    .status_o (q_status)
  );

  csp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_status.empty),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .radius_i     (radius_q),
    .half_i       (length_q[csp_pkg::RadiusW-1:1]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .support_x_o  (support_x_o),
    .support_y_o  (support_y_o),
    .support_z_o  (support_z_o)
  );

  assign x_ext   = {support_x_o[31], support_x_o};
  assign rad_ext = {2'b00, radius_q};

  // The front end only holds off input when its last stage cannot drain.
  `CSP_ASSERT(a_stall_means_full, !in_ready_o |-> q_status.full, "input stalled, queue not full")
  `CSP_ASSERT(a_queue_sane, !(q_status.full && q_status.empty), "queue full and empty")
  // The spherical part never leaves the radius on x.
  `CSP_ASSERT(a_x_in_radius, out_valid_o |-> (x_ext <= rad_ext && x_ext >= -rad_ext), "x beyond radius")

endmodule
